@@ rtl/slps_pkg.sv @@
package slps_pkg;

  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned WAIT_W   = PERIOD_W + 1;
  localparam int unsigned LED_W    = 8;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET = 24'd300000;
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RESET = 24'd150000;

  localparam logic [8:0] POS_RESET        = 9'd1;
  localparam logic [8:0] SWEEP_UP_RESET   = 9'd16;
  localparam logic [7:0] SWEEP_LO_RESET   = 8'd8;
  localparam logic [8:0] SWEEP_UP_WRAP    = 9'd256;
  localparam logic [8:0] SWEEP_UP_IN_WRAP = 9'd8;
  localparam logic [8:0] SWEEP_UP_IN_LOAD = 9'd128;
  localparam logic [7:0] SWEEP_LO_IN_LOAD = 8'd1;
  localparam logic [8:0] POS_LEFT_LOAD    = 9'd1;
  localparam logic [8:0] POS_RIGHT_LOAD   = 9'd128;

  // Register select is paddr bit 2; the low address bits are ignored.
  localparam logic REG_SLOW_PERIOD = 1'b0;
  localparam logic REG_FAST_PERIOD = 1'b1;

  typedef struct packed {
    logic count_on;
    logic shift_on;
    logic sweep_on;
  } marks_t;

  typedef struct packed {
    logic             stopped;
    logic             buzzer;
    logic [LED_W-1:0] led_bits;
  } result_t;

endpackage

@@ rtl/switch_led_pattern_sequencer_unit.sv @@
// Result beats are registered; each appears in the cycle after its input is accepted.
// Throughput: one input beat per cycle; the output register decouples the
// two sides, so a new beat is taken whenever the result is empty or taken.
// Reset (rst, synchronous, active high) restores the periods, the pattern
// state, the served marks, and clears the wait counter, buzzer and stop flag.
module switch_led_pattern_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slps_pkg::ADDR_W-1:0]      paddr,
  input  logic [slps_pkg::DATA_W-1:0]      pwdata,
  output logic [slps_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Fields from bit 0: count_on, shift_on, sweep_on, reverse, fast, pause,
  // buzz_on, halt.
  input  logic [7:0]                       s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Fields from bit 0: led_bits[7:0], buzzer, stopped, zero padding.
  output logic [15:0]                      m_tdata
);
  import slps_pkg::*;

  logic [PERIOD_W-1:0] slow_period;
  logic [PERIOD_W-1:0] fast_period;

  logic [LED_W-1:0]  led_value,    led_value_next;
  logic [8:0]        single_pos,   single_pos_next;
  logic [8:0]        sweep_upper,  sweep_upper_next;
  logic [7:0]        sweep_lower,  sweep_lower_next;
  logic [WAIT_W-1:0] wait_ticks,   wait_ticks_next;
  marks_t            served,       served_next;
  logic              buzzer_level, buzzer_level_next;
  logic              halted,       halted_next;
  result_t           result;

  logic count_on, shift_on, sweep_on, reverse, fast, pause, buzz_on, halt;
  logic any_mode;
  logic s_accept;
  logic [8:0] pos_load;
  logic [8:0] up_shift;
  logic [7:0] lo_shift;
  logic [WAIT_W-1:0] buzz_wait;
  logic [WAIT_W-1:0] step_wait;

  assign {halt, buzz_on, pause, fast, reverse, sweep_on, shift_on, count_on} = s_tdata;
  assign any_mode = count_on | shift_on | sweep_on;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FAST_PERIOD) ?
                  {{(DATA_W-PERIOD_W){1'b0}}, fast_period} :
                  {{(DATA_W-PERIOD_W){1'b0}}, slow_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_period <= SLOW_PERIOD_RESET;
      fast_period <= FAST_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SLOW_PERIOD: slow_period <= pwdata[PERIOD_W-1:0];
        REG_FAST_PERIOD: fast_period <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    led_value_next    = led_value;
    single_pos_next   = single_pos;
    sweep_upper_next  = sweep_upper;
    sweep_lower_next  = sweep_lower;
    wait_ticks_next   = wait_ticks;
    served_next       = served;
    buzzer_level_next = buzzer_level;
    halted_next       = halted;
    pos_load          = single_pos;
    up_shift          = sweep_upper;
    lo_shift          = sweep_lower;
    buzz_wait         = '0;
    step_wait         = '0;

    if (!halted) begin
      if (wait_ticks != '0) begin
        wait_ticks_next = wait_ticks - WAIT_W'(1);
      end else if (halt) begin
        halted_next    = 1'b1;
        led_value_next = '0;
      end else if (!(pause && any_mode)) begin
        if (buzz_on) begin
          buzzer_level_next = ~buzzer_level;
          buzz_wait         = {1'b0, slow_period};
        end
        if (any_mode) begin
          if (sweep_on) begin
            served_next.sweep_on = 1'b1;
            led_value_next = sweep_upper[7:0] | sweep_lower;
            if (!reverse) begin
              up_shift = {sweep_upper[7:0], 1'b0};
              lo_shift = {1'b0, sweep_lower[7:1]};
              if (up_shift == SWEEP_UP_WRAP) begin
                sweep_upper_next = SWEEP_UP_RESET;
                sweep_lower_next = SWEEP_LO_RESET;
              end else begin
                sweep_upper_next = up_shift;
                sweep_lower_next = lo_shift;
              end
            end else begin
              up_shift = {1'b0, sweep_upper[8:1]};
              lo_shift = {sweep_lower[6:0], 1'b0};
              if (up_shift == SWEEP_UP_IN_WRAP) begin
                sweep_upper_next = SWEEP_UP_IN_LOAD;
                sweep_lower_next = SWEEP_LO_IN_LOAD;
              end else begin
                sweep_upper_next = up_shift;
                sweep_lower_next = lo_shift;
              end
            end
          end else if (shift_on) begin
            served_next.shift_on = 1'b1;
            if (single_pos[7:0] == 8'd0) begin
              pos_load = reverse ? POS_RIGHT_LOAD : POS_LEFT_LOAD;
            end
            led_value_next  = pos_load[7:0];
            single_pos_next = reverse ? {1'b0, pos_load[8:1]} : {pos_load[7:0], 1'b0};
          end else begin
            served_next.count_on = 1'b1;
            led_value_next = reverse ? led_value - 8'd1 : led_value + 8'd1;
          end
          step_wait = {1'b0, (fast ? fast_period : slow_period)};
        end
        if (!sweep_on && served_next.sweep_on) begin
          served_next.sweep_on = 1'b0;
          led_value_next       = '0;
        end
        if (!shift_on && served_next.shift_on) begin
          served_next.shift_on = 1'b0;
          led_value_next       = '0;
        end
        if (!count_on && served_next.count_on) begin
          served_next.count_on = 1'b0;
          led_value_next       = '0;
        end
        wait_ticks_next = buzz_wait + step_wait;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_value    <= '0;
      single_pos   <= POS_RESET;
      sweep_upper  <= SWEEP_UP_RESET;
      sweep_lower  <= SWEEP_LO_RESET;
      wait_ticks   <= '0;
      served       <= '1;
      buzzer_level <= 1'b0;
      halted       <= 1'b0;
    end else if (s_accept) begin
      led_value    <= led_value_next;
      single_pos   <= single_pos_next;
      sweep_upper  <= sweep_upper_next;
      sweep_lower  <= sweep_lower_next;
      wait_ticks   <= wait_ticks_next;
      served       <= served_next;
      buzzer_level <= buzzer_level_next;
      halted       <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      result.stopped  <= halted_next;
      result.buzzer   <= buzzer_level_next;
      result.led_bits <= halted_next ? '0 : led_value_next;
    end
  end

  assign m_tdata = {6'b0, result};

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("stop flag dropped without reset");

  a_stopped_blank: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9]) |-> (m_tdata[7:0] == 8'd0))
    else $error("LEDs lit while stopped");

  a_wait_counts: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !halted && wait_ticks != '0) |=>
      (wait_ticks == $past(wait_ticks) - WAIT_W'(1)))
    else $error("wait counter did not count down");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result beat stalled");

endmodule
